FILE: hw/rtl/esa_pkg.sv
`timescale 1ns / 1ps
package esa_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_RUN,
      ST_WRITE,
      ST_RESP
   } esa_state_type;

   // Request kinds.
   localparam logic [1:0] REQ_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_STEP   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_SET    = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_FIT   = 2'd2;
   localparam logic [1:0] STATUS_INDEX = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_INPUT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_COUNT = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_BASE  = 2'd2;
   localparam logic [1:0] CSR_ACC_BASE     = 2'd3;

   localparam int MAX_WIDTH   = 256;
   localparam int LANE_FIELDS = 4;

endpackage

FILE: hw/rtl/event_driven_synapse_accumulator_top.sv
`timescale 1ns / 1ps
// Event-driven synapse accumulator.
//
// A request arrives on the req_ channel (valid/ready) and produces exactly one
// response on the rsp_ channel. A request writes one signed 8-bit weight,
// reads or sets one 32-bit accumulator, or runs an accumulate step that adds,
// for every output of the group, the weights selected by up to four lane
// events to that output's accumulator.
// The block handles one request at a time. Weight writes, accumulator sets and
// rejected requests present their response in the cycle after acceptance; reads
// first pass through the read state.
// An accumulate step walks the outputs one by one; for each output it reads the
// lane weights in turn through the single read port of the weight memory, then
// does the read-modify-write of the accumulator memory.
// Configuration registers are written through the csr_ port; the user must do
// so only while idle, as the block does not enforce it. After reset the
// accumulator memory is cleared one entry per cycle, with req_ready held low.
// The response is held in output registers until rsp_ready is seen; a new
// request is taken only after the pending response has been delivered.
module event_driven_synapse_accumulator_top #(
   parameter int INPUT_LANES  = 4,
   parameter int OUTPUT_LANES = 8,
   parameter int WEIGHT_DEPTH = 16384,
   parameter int ACC_DEPTH    = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [13:0]        req_address,
   input  logic signed [31:0] req_write_data,
   input  logic [3:0]         req_event_mask,
   input  logic [7:0]         req_event_index_0,
   input  logic [7:0]         req_event_index_1,
   input  logic [7:0]         req_event_index_2,
   input  logic [7:0]         req_event_index_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_data,
   output logic [31:0]        rsp_compute_cycles,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_write_data
);
   import esa_pkg::*;

   localparam int WA    = $clog2(WEIGHT_DEPTH);
   localparam int AA    = $clog2(ACC_DEPTH);
   localparam int LANES = (INPUT_LANES < LANE_FIELDS) ? INPUT_LANES : LANE_FIELDS;
   localparam int GW    = (OUTPUT_LANES > 1) ? $clog2(OUTPUT_LANES) : 1;
   localparam logic [3:0] LANE_MASK = 4'((1 << LANES) - 1);

   // Configuration registers.
   logic [8:0]  cfg_iw_ff;
   logic [8:0]  cfg_oc_ff;
   logic [14:0] cfg_wbase_ff;
   logic [7:0]  cfg_abase_ff;

   // Control state.
   esa_state_type state_ff, state_in;
   logic [AA-1:0] clr_ff, clr_in;
   logic [31:0]   cycle_total_ff, cycle_total_in;
   logic [2:0]    lane_ff, lane_in;
   logic          pend_ff, pend_in;
   logic          pend_acc_ff, pend_acc_in;

   // Working payload.
   logic [3:0]         mask_ff, mask_in;
   logic [7:0]         idx_ff [LANE_FIELDS];
   logic [7:0]         idx_in [LANE_FIELDS];
   logic [WA-1:0]      row_ff, row_in;
   logic [AA-1:0]      acc_idx_ff, acc_idx_in;
   logic [8:0]         out_cnt_ff, out_cnt_in;
   logic [GW-1:0]      grp_ff, grp_in;
   logic signed [10:0] sum_ff, sum_in;
   logic [31:0]        accv_ff, accv_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic          w_we, w_re;
   logic [WA-1:0] w_wa, w_ra;
   logic [7:0]    w_wd, w_rd;
   logic          a_we, a_re;
   logic [AA-1:0] a_wa, a_ra;
   logic [31:0]   a_wd, a_rd;

   // Accumulate step admission checks.
   logic [17:0] span;
   logic        fit_bad, index_bad, step_go;
   logic [1:0]  step_status;
   logic [7:0]  req_idx [LANE_FIELDS];

   assign req_idx[0] = req_event_index_0;
   assign req_idx[1] = req_event_index_1;
   assign req_idx[2] = req_event_index_2;
   assign req_idx[3] = req_event_index_3;

   assign span = 18'(cfg_iw_ff) * 18'(cfg_oc_ff);

   always_comb begin
      fit_bad = (cfg_iw_ff == 9'd0) || (32'(cfg_iw_ff) > 32'(MAX_WIDTH))
         || (32'(cfg_wbase_ff) > 32'(WEIGHT_DEPTH))
         || (32'(span) > 32'(WEIGHT_DEPTH) - 32'(cfg_wbase_ff))
         || (32'(cfg_abase_ff) + 32'(cfg_oc_ff) > 32'(ACC_DEPTH));
      index_bad = 1'b0;
      for (int l = 0; l < LANE_FIELDS; l++) begin
         if (LANE_MASK[l] && req_event_mask[l] && ({1'b0, req_idx[l]} >= cfg_iw_ff)) begin
            index_bad = 1'b1;
         end
      end
      step_go = ((req_event_mask & LANE_MASK) != 4'd0) && (cfg_oc_ff != 9'd0);
      if (fit_bad) begin
         step_status = STATUS_FIT;
      end else if (index_bad) begin
         step_status = STATUS_INDEX;
      end else begin
         step_status = STATUS_OK;
      end
   end

   // Next state and memory control.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cycle_total_in = cycle_total_ff;
      lane_in        = lane_ff;
      pend_in        = 1'b0;
      pend_acc_in    = 1'b0;
      mask_in        = mask_ff;
      idx_in         = idx_ff;
      row_in         = row_ff;
      acc_idx_in     = acc_idx_ff;
      out_cnt_in     = out_cnt_ff;
      grp_in         = grp_ff;
      sum_in         = sum_ff;
      accv_in        = accv_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      w_we = 1'b0;
      w_wa = WA'(req_address);
      w_wd = req_write_data[7:0];
      w_re = 1'b0;
      w_ra = WA'(32'(row_ff) + 32'(idx_ff[lane_ff[1:0]]));
      a_we = 1'b0;
      a_wa = acc_idx_ff;
      a_wd = accv_ff + 32'(sum_ff);
      a_re = 1'b0;
      a_ra = acc_idx_ff;

      // Weight and accumulator read data return in the cycle after the read is issued.
      if (pend_ff) begin
         sum_in = sum_ff + 11'($signed(w_rd));
      end
      if (pend_acc_ff) begin
         accv_in = a_rd;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            a_we   = 1'b1;
            a_wa   = clr_ff;
            a_wd   = 32'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AA'(ACC_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rsp_data_in   = 32'd0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_RESP;
               unique case (req_type)
                  REQ_WEIGHT: begin
                     if ((32'(req_address) >= 32'(WEIGHT_DEPTH))
                         || (req_write_data > 32'sd127) || (req_write_data < -32'sd128)) begin
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        w_we = 1'b1;
                     end
                  end
                  REQ_STEP: begin
                     rsp_status_in = step_status;
                     mask_in       = req_event_mask & LANE_MASK;
                     idx_in        = req_idx;
                     row_in        = WA'(cfg_wbase_ff);
                     acc_idx_in    = AA'(cfg_abase_ff);
                     out_cnt_in    = 9'd0;
                     grp_in        = '0;
                     lane_in       = 3'd0;
                     sum_in        = '0;
                     if (step_status == STATUS_OK && step_go) begin
                        state_in = ST_RUN;
                     end
                  end
                  REQ_READ: begin
                     if (32'(req_address) >= 32'(ACC_DEPTH)) begin
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        a_re     = 1'b1;
                        a_ra     = AA'(req_address);
                        state_in = ST_READ;
                     end
                  end
                  REQ_SET: begin
                     if (32'(req_address) >= 32'(ACC_DEPTH)) begin
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        a_we = 1'b1;
                        a_wa = AA'(req_address);
                        a_wd = req_write_data;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_BAD;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_data_in = a_rd;
            state_in    = ST_RESP;
         end
         ST_RUN: begin
            if (lane_ff < 3'(LANES)) begin
               w_re    = 1'b1;
               pend_in = mask_ff[lane_ff[1:0]];
               if (lane_ff == 3'd0) begin
                  a_re        = 1'b1;
                  pend_acc_in = 1'b1;
               end
               lane_in = lane_ff + 3'd1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            a_we = 1'b1;
            if (grp_ff == '0) begin
               cycle_total_in = cycle_total_ff + 32'd1;
            end
            if (grp_ff == GW'(OUTPUT_LANES - 1)) begin
               grp_in = '0;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
            if (10'(out_cnt_ff) + 10'd1 == 10'(cfg_oc_ff)) begin
               state_in = ST_RESP;
            end else begin
               state_in   = ST_RUN;
               lane_in    = 3'd0;
               sum_in     = '0;
               row_in     = WA'(32'(row_ff) + 32'(cfg_iw_ff));
               acc_idx_in = acc_idx_ff + 1'b1;
               out_cnt_in = out_cnt_ff + 9'd1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         cycle_total_ff <= 32'd0;
         lane_ff        <= 3'd0;
         pend_ff        <= 1'b0;
         pend_acc_ff    <= 1'b0;
         cfg_iw_ff      <= 9'd1;
         cfg_oc_ff      <= 9'd1;
         cfg_wbase_ff   <= 15'd0;
         cfg_abase_ff   <= 8'd0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         cycle_total_ff <= cycle_total_in;
         lane_ff        <= lane_in;
         pend_ff        <= pend_in;
         pend_acc_ff    <= pend_acc_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_INPUT_WIDTH:  cfg_iw_ff    <= csr_write_data[8:0];
               CSR_OUTPUT_COUNT: cfg_oc_ff    <= csr_write_data[8:0];
               CSR_WEIGHT_BASE:  cfg_wbase_ff <= csr_write_data;
               CSR_ACC_BASE:     cfg_abase_ff <= csr_write_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      acc_idx_ff    <= acc_idx_in;
      out_cnt_ff    <= out_cnt_in;
      grp_ff        <= grp_in;
      sum_ff        <= sum_in;
      accv_ff       <= accv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   esa_ram #(.WIDTH(8), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_wa),
      .wr_data (w_wd),
      .rd_en   (w_re),
      .rd_addr (w_ra),
      .rd_data (w_rd)
   );

   esa_ram #(.WIDTH(32), .DEPTH(ACC_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_wa),
      .wr_data (a_wd),
      .rd_en   (a_re),
      .rd_addr (a_ra),
      .rd_data (a_rd)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_compute_cycles = cycle_total_ff;

   // A new request is never taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // The accumulator is written back only after every lane has been read.
   a_write_after_lanes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (lane_ff == 3'(LANES)))
      else $error("accumulator written before all lanes were read");

   // The output walk never passes the configured output count.
   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (10'(out_cnt_ff) < 10'(cfg_oc_ff)))
      else $error("output counter ran past output count");

   // A rejected request leaves the cycle counter untouched.
   a_reject_no_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_status_ff != STATUS_OK) |->
      (cycle_total_ff == $past(cycle_total_ff)))
      else $error("cycle counter moved on a rejected request");

endmodule

FILE: hw/rtl/esa_ram.sv
`timescale 1ns / 1ps
module esa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
